/* sv/spi_master_fifo_controller_defines.svh */
// ----------------------------------------------------------------------------
// SPI master FIFO controller assertion macros
// Clocked assertion helpers shared by the controller and its FIFOs.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_FIFO_CONTROLLER_DEFINES_SVH
`define SPI_MASTER_FIFO_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define SMFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition that must hold on every edge outside reset.
`define SMFC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

`else

`define SMFC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define SMFC_ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

/* sv/smfc_pkg.sv */
// ----------------------------------------------------------------------------
// smfc_pkg
// Shared types, register offsets and constants of the SPI master controller.
// ----------------------------------------------------------------------------
package smfc_pkg;

    localparam int FIFO_DEPTH_DEF = 64;
    localparam int DATA_W         = 16;
    localparam int OFFSET_W       = 12;
    localparam int CFG_INDEX_W    = 3;
    localparam int BIT_CNT_W      = 5;

    localparam logic [DATA_W-1:0] BAUD_RESET = 16'd24;

    // Register byte offsets
    localparam logic [OFFSET_W-1:0] OFF_ENABLE = 12'h008;
    localparam logic [OFFSET_W-1:0] OFF_SELECT = 12'h00C;
    localparam logic [OFFSET_W-1:0] OFF_TXLVL  = 12'h01C;
    localparam logic [OFFSET_W-1:0] OFF_RXLVL  = 12'h020;
    localparam logic [OFFSET_W-1:0] OFF_STATUS = 12'h024;
    localparam logic [OFFSET_W-1:0] OFF_TXDATA = 12'h400;
    localparam logic [OFFSET_W-1:0] OFF_RXDATA = 12'h800;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CPOL     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CPHA     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME16  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOPBACK = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAUD     = 3'd4;

    localparam logic [BIT_CNT_W-1:0] FRAME_BITS_8  = 5'd8;
    localparam logic [BIT_CNT_W-1:0] FRAME_BITS_16 = 5'd16;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_fifo_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

endpackage

/* sv/spi_master_fifo_controller.sv */
// ----------------------------------------------------------------------------
// spi_master_fifo_controller
// SPI master behind a register map, with TX and RX FIFOs and a frame engine.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        slave      i_in_valid / o_in_ready    mode, reg_offset, write_value, miso_in
//  out       master     o_out_valid / i_out_ready  read_value, sclk_out, mosi_out, select_n_out
//  cfg       slave      i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
//  One transaction per clock sustained while the result side is not stalled.
//  Each item passes an input register, one pass of logic, then a result register.
//  FIFO front words are prefetched from the storage arrays into a registered head word.
//  Reset is synchronous; it clears control, pointers and the frame engine.
//  A stalled result holds the processing stage; the input register still
//  takes one transaction while the result waits.
// ----------------------------------------------------------------------------
`include "spi_master_fifo_controller_defines.svh"

module spi_master_fifo_controller
    import smfc_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [OFFSET_W-1:0]    i_reg_offset,
    input  logic [DATA_W-1:0]      i_write_value,
    input  logic                   i_miso_in,
    // results
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [DATA_W-1:0]      o_read_value,
    output logic                   o_sclk_out,
    output logic                   o_mosi_out,
    output logic                   o_select_n_out
);

    // configuration
    logic              r_cpol;
    logic              r_cpha;
    logic              r_frame16;
    logic              r_loop;
    logic [DATA_W-1:0] r_baud;

    // input register
    logic                r_in_valid;
    logic [1:0]          r_mode;
    logic [OFFSET_W-1:0] r_offset;
    logic [DATA_W-1:0]   r_wval;
    logic                r_miso;

    // engine state
    logic [DATA_W-1:0]    r_shift_out, n_shift_out;
    logic [DATA_W-1:0]    r_shift_in, n_shift_in;
    logic [BIT_CNT_W-1:0] r_bit_left, n_bit_left;
    logic [DATA_W-1:0]    r_tick, n_tick;
    logic                 r_clock_half, n_clock_half;
    logic                 r_enabled, n_enabled;
    logic                 r_selected, n_selected;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_value, n_read_value;
    logic              r_sclk, n_sclk;
    logic              r_mosi, n_mosi;
    logic              r_select_n, n_select_n;

    // FIFO links
    t_fifo_ctrl        w_tx_ctrl;
    t_fifo_ctrl        w_rx_ctrl;
    t_fifo_flags       w_tx_flags;
    t_fifo_flags       w_rx_flags;
    logic [DATA_W-1:0] w_tx_head;
    logic [DATA_W-1:0] w_rx_head;
    logic [CW-1:0]     w_tx_count;
    logic [CW-1:0]     w_rx_count;

    logic          w_fire;
    logic [14:0]   w_half;
    logic          w_sample;
    logic          w_busy;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    assign w_half   = (r_baud[15:1] == '0) ? 15'd1 : r_baud[15:1];
    assign w_sample = r_loop ? r_shift_out[DATA_W-1] : r_miso;
    assign w_busy   = (r_bit_left != '0) || (r_enabled && !w_tx_flags.empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpol    <= 1'b0;
            r_cpha    <= 1'b0;
            r_frame16 <= 1'b0;
            r_loop    <= 1'b0;
            r_baud    <= BAUD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CPOL:     r_cpol    <= i_cfg_data[0];
                CFG_CPHA:     r_cpha    <= i_cfg_data[0];
                CFG_FRAME16:  r_frame16 <= i_cfg_data[0];
                CFG_LOOPBACK: r_loop    <= i_cfg_data[0];
                CFG_BAUD:     r_baud    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode   <= i_mode;
            r_offset <= i_reg_offset;
            r_wval   <= i_write_value;
            r_miso   <= i_miso_in;
        end
    end

    always_comb begin
        n_shift_out  = r_shift_out;
        n_shift_in   = r_shift_in;
        n_bit_left   = r_bit_left;
        n_tick       = r_tick;
        n_clock_half = r_clock_half;
        n_enabled    = r_enabled;
        n_selected   = r_selected;
        n_read_value = '0;
        w_tx_ctrl    = '0;
        w_rx_ctrl    = '0;

        if (w_fire) begin
            unique case (t_mode'(r_mode))
                MODE_TICK: begin
                    if (r_enabled) begin
                        if (r_bit_left == '0) begin
                            // start a frame from the TX front word
                            if (!w_tx_flags.empty) begin
                                w_tx_ctrl.pop = 1'b1;
                                if (r_frame16) begin
                                    n_shift_out = w_tx_head;
                                    n_bit_left  = FRAME_BITS_16;
                                end else begin
                                    n_shift_out = {w_tx_head[7:0], 8'h00};
                                    n_bit_left  = FRAME_BITS_8;
                                end
                                n_shift_in   = '0;
                                n_tick       = '0;
                                n_clock_half = 1'b0;
                            end
                        end else begin
                            n_tick = r_tick + 1'b1;
                            if (n_tick >= {1'b0, w_half}) begin
                                n_tick = '0;
                                if (!r_clock_half) begin
                                    if (!r_cpha) begin
                                        n_shift_in = {r_shift_in[DATA_W-2:0], w_sample};
                                    end
                                    n_clock_half = 1'b1;
                                end else begin
                                    if (r_cpha) begin
                                        n_shift_in = {r_shift_in[DATA_W-2:0], w_sample};
                                    end
                                    n_clock_half = 1'b0;
                                    n_shift_out  = {r_shift_out[DATA_W-2:0], 1'b0};
                                    n_bit_left   = r_bit_left - 1'b1;
                                    // last bit: push the frame unless RX is full
                                    if (r_bit_left == 5'd1 && !w_rx_flags.full) begin
                                        w_rx_ctrl.push = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                MODE_WRITE: begin
                    unique case (r_offset)
                        OFF_ENABLE: begin
                            if (r_wval[0]) begin
                                n_enabled = 1'b1;
                            end else begin
                                // drop queued data and abort the frame
                                n_enabled       = 1'b0;
                                w_tx_ctrl.clear = 1'b1;
                                w_rx_ctrl.clear = 1'b1;
                                n_shift_out     = '0;
                                n_shift_in      = '0;
                                n_bit_left      = '0;
                                n_tick          = '0;
                                n_clock_half    = 1'b0;
                            end
                        end
                        OFF_SELECT: n_selected = r_wval[0];
                        OFF_TXDATA: w_tx_ctrl.push = !w_tx_flags.full;
                        default: ;
                    endcase
                end
                MODE_READ: begin
                    unique case (r_offset)
                        OFF_ENABLE: n_read_value = DATA_W'(r_enabled);
                        OFF_SELECT: n_read_value = DATA_W'(r_selected);
                        OFF_TXLVL:  n_read_value = DATA_W'(w_tx_count);
                        OFF_RXLVL:  n_read_value = DATA_W'(w_rx_count);
                        OFF_STATUS: n_read_value = DATA_W'(w_busy);
                        OFF_RXDATA: begin
                            if (!w_rx_flags.empty) begin
                                n_read_value   = w_rx_head;
                                w_rx_ctrl.pop  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                MODE_NOP: ;
            endcase
        end

        n_sclk     = r_cpol ^ ((n_bit_left != '0) && n_clock_half);
        n_mosi     = (n_bit_left != '0) ? n_shift_out[DATA_W-1] : 1'b0;
        n_select_n = !n_selected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_out  <= '0;
            r_shift_in   <= '0;
            r_bit_left   <= '0;
            r_tick       <= '0;
            r_clock_half <= 1'b0;
            r_enabled    <= 1'b0;
            r_selected   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_shift_out  <= n_shift_out;
            r_shift_in   <= n_shift_in;
            r_bit_left   <= n_bit_left;
            r_tick       <= n_tick;
            r_clock_half <= n_clock_half;
            r_enabled    <= n_enabled;
            r_selected   <= n_selected;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_value <= n_read_value;
            r_sclk       <= n_sclk;
            r_mosi       <= n_mosi;
            r_select_n   <= n_select_n;
        end
    end

    smfc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_tx_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_tx_ctrl),
        .i_push_data (r_wval),
        .o_head_data (w_tx_head),
        .o_count     (w_tx_count),
        .o_flags     (w_tx_flags)
    );

    smfc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_rx_ctrl),
        .i_push_data (n_shift_in),
        .o_head_data (w_rx_head),
        .o_count     (w_rx_count),
        .o_flags     (w_rx_flags)
    );

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_read_value;
    assign o_sclk_out     = r_sclk;
    assign o_mosi_out     = r_mosi;
    assign o_select_n_out = r_select_n;

    `SMFC_ASSERT_IMP(a_half_in_frame, i_clk, i_rst_n, r_clock_half, r_bit_left != '0)
    `SMFC_ASSERT_IMP(a_frame_needs_en, i_clk, i_rst_n, r_bit_left != '0, r_enabled)
    `SMFC_ASSERT_NEXT(a_frame_start, i_clk, i_rst_n,
        w_fire && (r_mode == MODE_TICK) && r_enabled && (r_bit_left == '0)
            && !w_tx_flags.empty,
        (r_bit_left == FRAME_BITS_8) || (r_bit_left == FRAME_BITS_16))

endmodule

/* sv/smfc_fifo.sv */
// ----------------------------------------------------------------------------
// smfc_fifo
// Ring-buffer FIFO with a registered head word that always shows the front.
// ----------------------------------------------------------------------------
`include "spi_master_fifo_controller_defines.svh"

module smfc_fifo
    import smfc_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fifo_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_push_data,
    output logic [DATA_W-1:0] o_head_data,
    output logic [CW-1:0]     o_count,
    output t_fifo_flags       o_flags
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_head_data;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     n_head;
    logic [AW-1:0]     n_tail;
    logic [CW-1:0]     n_count;
    logic              w_full;
    logic              w_empty;
    logic              w_wr;
    logic              w_rd;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_wr    = i_ctrl.push && !w_full && !i_ctrl.clear;
    assign w_rd    = i_ctrl.pop && !w_empty && !i_ctrl.clear;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (!i_rst_n || i_ctrl.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else begin
            if (w_rd) begin
                n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (w_wr) begin
                n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (w_wr && !w_rd) begin
                n_count = r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_tail  <= n_tail;
        r_count <= n_count;
    end

    // Prefetch the next front word; forward a write that lands on it.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_tail] <= i_push_data;
        end
        if (w_wr && (r_tail == n_head)) begin
            r_head_data <= i_push_data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_head_data   = r_head_data;
    assign o_count       = r_count;
    assign o_flags.full  = w_full;
    assign o_flags.empty = w_empty;

    `SMFC_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `SMFC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_ctrl.push, !w_full)
    `SMFC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_ctrl.pop, !w_empty)

endmodule

/* test/spi_master_fifo_controller_tb.sv */
// ----------------------------------------------------------------------------
// spi_master_fifo_controller_tb
// Drives register reads, writes, ticks and no-ops into the SPI master, with random
// gaps on both handshakes, and checks every result against a cycle-free
// model of the register map, FIFOs and frame engine kept in this module.
// ----------------------------------------------------------------------------
module spi_master_fifo_controller_tb;
    import smfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = FIFO_DEPTH_DEF;
    localparam int OP_TARGET = 1850;
    localparam int FLOOD_AT  = 5;

    typedef struct packed {
        t_mode                mode;
        logic [OFFSET_W-1:0]  offset;
        logic [DATA_W-1:0]    wdata;
        logic                 miso;
    } t_bus_op;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              sclk;
        logic              mosi;
        logic              cs_n;
    } t_pin_state;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [DATA_W-1:0]      i_cfg_data    = '0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_mode        = '0;
    logic [OFFSET_W-1:0]    i_reg_offset  = '0;
    logic [DATA_W-1:0]      i_write_value = '0;
    logic                   i_miso_in     = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready   = 1'b0;
    logic [DATA_W-1:0]      o_read_value;
    logic                   o_sclk_out;
    logic                   o_mosi_out;
    logic                   o_select_n_out;

    spi_master_fifo_controller uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_reg_offset   (i_reg_offset),
        .i_write_value  (i_write_value),
        .i_miso_in      (i_miso_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_value   (o_read_value),
        .o_sclk_out     (o_sclk_out),
        .o_mosi_out     (o_mosi_out),
        .o_select_n_out (o_select_n_out)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_bus_op    ops_queue[$];
    t_pin_state resp_queue[$];
    t_bus_op    cur_op;
    t_pin_state want;
    int         op_total     = 0;
    int         mismatch_cnt = 0;
    int         send_gap     = 0;
    int         stall_left   = 0;
    logic       in_taken     = 1'b0;
    bit         calm         = 1'b0;

    // Model of the register map, both FIFOs and the frame engine
    logic [DATA_W-1:0] txq_mem [DEPTH];
    logic [DATA_W-1:0] rxq_mem [DEPTH];
    int                txq_rd    = 0;
    int                txq_lvl   = 0;
    int                rxq_rd    = 0;
    int                rxq_lvl   = 0;
    logic [DATA_W-1:0] sh_tx     = '0;
    logic [DATA_W-1:0] sh_rx     = '0;
    int                bits_todo = 0;
    int                half_cnt  = 0;
    logic              sclk_hi   = 1'b0;
    logic              ctl_en    = 1'b0;
    logic              ctl_sel   = 1'b0;
    logic              cfg_cpol  = 1'b0;
    logic              cfg_cpha  = 1'b0;
    logic              cfg_wide  = 1'b0;
    logic              cfg_loop  = 1'b0;
    logic [DATA_W-1:0] cfg_div   = BAUD_RESET;

    function automatic logic serial_out();
        return (bits_todo != 0) ? sh_tx[DATA_W-1] : 1'b0;
    endfunction

    function automatic void capture_bit(input logic miso);
        sh_rx = {sh_rx[DATA_W-2:0], cfg_loop ? serial_out() : miso};
    endfunction

    function automatic t_pin_state spi_ctrl_step(input t_bus_op op);
        t_pin_state        r;
        logic [DATA_W-1:0] word;
        int                half;
        r.rdata = '0;
        case (op.mode)
            MODE_TICK: begin
                if (ctl_en && bits_todo == 0) begin
                    if (txq_lvl != 0) begin
                        word    = txq_mem[txq_rd];
                        txq_rd  = (txq_rd + 1) % DEPTH;
                        txq_lvl = txq_lvl - 1;
                        // frame length latches here
                        sh_tx     = cfg_wide ? word : {word[7:0], 8'h00};
                        bits_todo = cfg_wide ? int'(FRAME_BITS_16) : int'(FRAME_BITS_8);
                        sh_rx     = '0;
                        half_cnt  = 0;
                        sclk_hi   = 1'b0;
                    end
                end else if (ctl_en) begin
                    half = int'(cfg_div[DATA_W-1:1]);
                    if (half == 0) half = 1;
                    half_cnt = (half_cnt + 1) & 'hFFFF;
                    if (half_cnt >= half) begin
                        half_cnt = 0;
                        if (!sclk_hi) begin
                            if (!cfg_cpha) capture_bit(op.miso);
                            sclk_hi = 1'b1;
                        end else begin
                            if (cfg_cpha) capture_bit(op.miso);
                            sclk_hi   = 1'b0;
                            sh_tx     = sh_tx << 1;
                            bits_todo = bits_todo - 1;
                            // drop the received word when RX is full
                            if (bits_todo == 0 && rxq_lvl < DEPTH) begin
                                rxq_mem[(rxq_rd + rxq_lvl) % DEPTH] = sh_rx;
                                rxq_lvl = rxq_lvl + 1;
                            end
                        end
                    end
                end
            end
            MODE_WRITE: begin
                case (op.offset)
                    OFF_ENABLE: begin
                        ctl_en = op.wdata[0];
                        if (!op.wdata[0]) begin
                            txq_rd    = 0;
                            txq_lvl   = 0;
                            rxq_rd    = 0;
                            rxq_lvl   = 0;
                            sh_tx     = '0;
                            sh_rx     = '0;
                            bits_todo = 0;
                            half_cnt  = 0;
                            sclk_hi   = 1'b0;
                        end
                    end
                    OFF_SELECT: ctl_sel = op.wdata[0];
                    OFF_TXDATA: begin
                        if (txq_lvl < DEPTH) begin
                            txq_mem[(txq_rd + txq_lvl) % DEPTH] = op.wdata;
                            txq_lvl = txq_lvl + 1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_READ: begin
                case (op.offset)
                    OFF_ENABLE: r.rdata = DATA_W'(ctl_en);
                    OFF_SELECT: r.rdata = DATA_W'(ctl_sel);
                    OFF_TXLVL:  r.rdata = DATA_W'(txq_lvl);
                    OFF_RXLVL:  r.rdata = DATA_W'(rxq_lvl);
                    OFF_STATUS: r.rdata = DATA_W'(bits_todo != 0 || (ctl_en && txq_lvl != 0));
                    OFF_RXDATA: begin
                        if (rxq_lvl != 0) begin
                            r.rdata = rxq_mem[rxq_rd];
                            rxq_rd  = (rxq_rd + 1) % DEPTH;
                            rxq_lvl = rxq_lvl - 1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.sclk = cfg_cpol ^ ((bits_todo != 0) && sclk_hi);
        r.mosi = serial_out();
        r.cs_n = !ctl_sel;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OFFSET_W-1:0] known_offset(input int k);
        case (k)
            0:       return OFF_ENABLE;
            1:       return OFF_SELECT;
            2:       return OFF_TXLVL;
            3:       return OFF_RXLVL;
            4:       return OFF_STATUS;
            5:       return OFF_TXDATA;
            default: return OFF_RXDATA;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 50) $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic push_op(input t_mode m, input logic [OFFSET_W-1:0] off,
                           input logic [DATA_W-1:0] val, input logic miso);
        t_bus_op op;
        op.mode   = m;
        op.offset = off;
        op.wdata  = val;
        op.miso   = miso;
        ops_queue.push_back(op);
        op_total++;
    endtask

    // Ticks with random line data; optionally slip register reads in between.
    task automatic push_ticks(input int n, input bit probes);
        for (int k = 0; k < n; k++) begin
            if (probes && $urandom_range(0, 7) == 0)
                push_op(MODE_READ, known_offset($urandom_range(0, 6)), DATA_W'($urandom),
                        1'($urandom));
            push_op(MODE_TICK, OFFSET_W'($urandom), DATA_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic set_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_CPOL:     cfg_cpol = val[0];
            CFG_CPHA:     cfg_cpha = val[0];
            CFG_FRAME16:  cfg_wide = val[0];
            CFG_LOOPBACK: cfg_loop = val[0];
            CFG_BAUD:     cfg_div  = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (ops_queue.size() != 0 || i_in_valid || resp_queue.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Driver: present the next transaction once the previous one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (ops_queue.size() != 0) begin
                cur_op = ops_queue.pop_front();
                i_in_valid    <= 1'b1;
                i_mode        <= cur_op.mode;
                i_reg_offset  <= cur_op.offset;
                i_write_value <= cur_op.wdata;
                i_miso_in     <= cur_op.miso;
                send_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
        end
    end

    // Monitor: predict on input transactions, compare on result transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready)
                resp_queue.push_back(spi_ctrl_step({t_mode'(i_mode), i_reg_offset,
                                                    i_write_value, i_miso_in}));
            if (o_out_valid && i_out_ready) begin
                if (resp_queue.size() == 0) begin
                    flag_mismatch("result with nothing outstanding");
                end else begin
                    want = resp_queue.pop_front();
                    if (o_read_value !== want.rdata)
                        flag_mismatch($sformatf("read_value %h, want %h",
                                                o_read_value, want.rdata));
                    if (o_sclk_out !== want.sclk)
                        flag_mismatch($sformatf("sclk_out %b, want %b", o_sclk_out, want.sclk));
                    if (o_mosi_out !== want.mosi)
                        flag_mismatch($sformatf("mosi_out %b, want %b", o_mosi_out, want.mosi));
                    if (o_select_n_out !== want.cs_n)
                        flag_mismatch($sformatf("select_n_out %b, want %b",
                                                o_select_n_out, want.cs_n));
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("[spi_master_fifo_controller] ERROR");
        $finish;
    end

    initial begin
        int   div;
        int   half;
        int   bits;
        int   len;
        int   n;
        int   phase;
        logic wide;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register map after reset, odd offsets, then a frame aborted by disable
        push_op(MODE_READ, OFF_ENABLE, '0, 1'b0);
        push_op(MODE_READ, OFF_SELECT, '1, 1'b1);
        push_op(MODE_READ, OFF_TXLVL, '0, 1'b0);
        push_op(MODE_READ, OFF_RXLVL, '0, 1'b0);
        push_op(MODE_READ, OFF_STATUS, '0, 1'b0);
        push_op(MODE_READ, OFF_RXDATA, '0, 1'b0);
        push_op(MODE_READ, OFF_TXDATA, '0, 1'b0);
        push_op(MODE_READ, '1, '1, 1'b1);
        push_op(MODE_NOP, OFF_TXDATA, '1, 1'b1);
        push_op(MODE_WRITE, OFF_STATUS, '1, 1'b0);
        push_op(MODE_WRITE, OFF_ENABLE, '0, 1'b0);
        push_op(MODE_WRITE, OFF_SELECT, '1, 1'b0);
        push_op(MODE_WRITE, OFF_TXDATA, '1, 1'b0);
        push_op(MODE_WRITE, OFF_TXDATA, '0, 1'b0);
        push_op(MODE_TICK, '0, '0, 1'b1);
        push_op(MODE_READ, OFF_TXLVL, '0, 1'b0);
        push_op(MODE_READ, OFF_STATUS, '0, 1'b0);
        push_op(MODE_WRITE, OFF_ENABLE, DATA_W'(1), 1'b0);
        push_op(MODE_READ, OFF_STATUS, '0, 1'b0);
        push_op(MODE_READ, OFF_ENABLE, '0, 1'b0);
        push_op(MODE_TICK, '1, '1, 1'b1);
        push_op(MODE_TICK, '0, '0, 1'b0);
        push_op(MODE_TICK, '1, '1, 1'b1);
        push_op(MODE_READ, OFF_STATUS, '0, 1'b0);
        push_op(MODE_WRITE, OFF_ENABLE, '0, 1'b0);
        push_op(MODE_READ, OFF_TXLVL, '0, 1'b0);
        push_op(MODE_WRITE, OFF_SELECT, '0, 1'b0);

        phase = 0;
        while (op_total < OP_TARGET) begin
            // hold off until every outstanding result is back
            wait_idle();
            calm = ($urandom_range(0, 4) == 0);
            if (phase == 0)
                div = 65534;
            else if (phase == 1)
                div = 0;
            else if (phase == 2)
                div = 1;
            else if (phase == FLOOD_AT)
                div = 2;
            else if ($urandom_range(0, 7) == 0)
                div = $urandom_range(17, 65535);
            else
                div = $urandom_range(0, 8);
            wide = (phase == FLOOD_AT) ? 1'b0 : 1'($urandom);
            set_cfg(CFG_CPOL, DATA_W'({$urandom_range(0, 32767),
                                       (phase < 8) ? phase[0] : 1'($urandom)}));
            set_cfg(CFG_CPHA, DATA_W'({$urandom_range(0, 32767),
                                       (phase < 8) ? phase[1] : 1'($urandom)}));
            set_cfg(CFG_FRAME16, DATA_W'({$urandom_range(0, 32767), wide}));
            set_cfg(CFG_LOOPBACK, DATA_W'({$urandom_range(0, 32767),
                                           (phase < 8) ? phase[2] : 1'($urandom)}));
            set_cfg(CFG_BAUD, DATA_W'(div));
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            half = div / 2;
            if (half == 0) half = 1;
            bits = wide ? int'(FRAME_BITS_16) : int'(FRAME_BITS_8);
            len  = 1 + bits * 2 * half;

            if (phase == FLOOD_AT) begin
                // overfill TX while disabled, then run RX past full
                push_op(MODE_WRITE, OFF_ENABLE, '0, 1'b0);
                for (int k = 0; k < DEPTH + 2; k++)
                    push_op(MODE_WRITE, OFF_TXDATA, DATA_W'($urandom), 1'($urandom));
                push_op(MODE_READ, OFF_TXLVL, '0, 1'b0);
                push_op(MODE_READ, OFF_STATUS, '0, 1'b0);
                push_op(MODE_WRITE, OFF_ENABLE, DATA_W'(1), 1'b0);
                push_ticks(DEPTH * len + 4, 1'b0);
                for (int k = 0; k < 3; k++)
                    push_op(MODE_WRITE, OFF_TXDATA, DATA_W'($urandom), 1'($urandom));
                push_ticks(3 * len + 4, 1'b0);
                push_op(MODE_READ, OFF_RXLVL, '0, 1'b0);
                push_op(MODE_READ, OFF_STATUS, '0, 1'b0);
                for (int k = 0; k < 4; k++)
                    push_op(MODE_READ, OFF_RXDATA, '0, 1'b0);
                push_op(MODE_WRITE, OFF_ENABLE, '0, 1'b0);
            end else if (half > 8) begin
                // slow clock: run part of a frame, often abort it
                push_op(MODE_WRITE, OFF_ENABLE, DATA_W'($urandom) | DATA_W'(1), 1'b0);
                push_op(MODE_WRITE, OFF_SELECT, DATA_W'($urandom), 1'b0);
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    push_op(MODE_WRITE, OFF_TXDATA, DATA_W'($urandom), 1'($urandom));
                push_ticks($urandom_range(20, 80), 1'b1);
                push_op(MODE_READ, OFF_STATUS, '0, 1'b0);
                push_op(MODE_READ, OFF_RXDATA, '0, 1'b0);
                if ($urandom_range(0, 1) == 0)
                    push_op(MODE_WRITE, OFF_ENABLE, DATA_W'($urandom) & ~DATA_W'(1), 1'b0);
            end else if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(10, 40);
                for (int k = 0; k < n; k++)
                    push_op(t_mode'($urandom_range(0, 3)),
                            ($urandom_range(0, 1) == 0) ? known_offset($urandom_range(0, 6))
                                                        : OFFSET_W'($urandom),
                            DATA_W'($urandom), 1'($urandom));
            end else begin
                // queue a few words, clock them all out, drain RX plus one extra
                push_op(MODE_WRITE, OFF_ENABLE, DATA_W'($urandom) | DATA_W'(1), 1'b0);
                push_op(MODE_WRITE, OFF_SELECT, DATA_W'($urandom), 1'b0);
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    push_op(MODE_WRITE, OFF_TXDATA, DATA_W'($urandom), 1'($urandom));
                push_ticks(n * len + $urandom_range(0, 4), 1'b1);
                for (int k = 0; k <= n; k++)
                    push_op(MODE_READ, OFF_RXDATA, '0, 1'b0);
                push_op(MODE_READ, OFF_RXLVL, '0, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    push_op(MODE_WRITE, OFF_ENABLE, DATA_W'($urandom) & ~DATA_W'(1), 1'b0);
            end
            phase++;
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("[spi_master_fifo_controller] OK");
        else
            $display("[spi_master_fifo_controller] ERROR");
        $finish;
    end

endmodule
